// ----- hdl/chd_pkg.sv -----
// chd_pkg: shared types, constants and the arctangent table for the compass
// heading block. No dependencies.
package chd_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 12;

    localparam int ATAN_ENTRIES = 24;
    localparam int CORD_ITERS   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int DIV_STEPS    = 30;
    localparam int CNT_W        = 5;

    // datapath widths
    localparam int SMP_W  = 16;
    localparam int DEC_W  = 15;
    localparam int RNG_W  = 17;
    localparam int CTR_W  = 18;
    localparam int REM_W  = 18;
    localparam int QUO_W  = 30;
    localparam int NRM_W  = 31;
    localparam int CRD_W  = 34;
    localparam int HDG_W  = 16;
    localparam int SUM_W  = 18;

    localparam int ANG_SHIFT = 30 - ANGLE_FRAC_BITS;

    localparam logic signed [CRD_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam longint Q30_TWO_PI = 64'sd6746518852;
    localparam longint TWO_PI_Q =
        (Q30_TWO_PI + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    localparam logic signed [SUM_W-1:0] TWO_PI_ANG = SUM_W'(TWO_PI_Q);
    localparam logic signed [CRD_W-1:0] ANG_HALF = CRD_W'(64'sd1 <<< (ANG_SHIFT - 1));

    typedef struct packed {
        logic                    func;
        logic signed [SMP_W-1:0] x_raw;
        logic signed [SMP_W-1:0] y_raw;
    } t_in_item;

    typedef struct packed {
        logic signed [HDG_W-1:0] heading;
        logic                    calibrated;
    } t_out_item;

    typedef struct packed {
        logic             capture;
        logic             clear;
        logic             track;
        logic             div_init;
        logic             div_sel_y;
        logic             div_step;
        logic             div_store;
        logic             rot;
        logic             cord_step;
        logic [CNT_W-1:0] step_idx;
        logic             res_zero;
        logic             finish;
        logic             emit;
    } t_cmd;

    typedef struct packed {
        logic zero_range;
    } t_stat;

    function automatic logic signed [CRD_W-1:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic signed [CRD_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sh3243F6A8;
            5'd1:    v = 34'sh1DAC6705;
            5'd2:    v = 34'sh0FADBAFC;
            5'd3:    v = 34'sh07F56EA6;
            5'd4:    v = 34'sh03FEAB76;
            5'd5:    v = 34'sh01FFD55B;
            5'd6:    v = 34'sh00FFFAAA;
            5'd7:    v = 34'sh007FFF55;
            5'd8:    v = 34'sh003FFFEA;
            5'd9:    v = 34'sh001FFFFD;
            5'd10:   v = 34'sh000FFFFF;
            5'd11:   v = 34'sh0007FFFF;
            5'd12:   v = 34'sh0003FFFF;
            5'd13:   v = 34'sh0001FFFF;
            5'd14:   v = 34'sh0000FFFF;
            5'd15:   v = 34'sh00007FFF;
            5'd16:   v = 34'sh00003FFF;
            5'd17:   v = 34'sh00001FFF;
            5'd18:   v = 34'sh00000FFF;
            5'd19:   v = 34'sh000007FF;
            5'd20:   v = 34'sh000003FF;
            5'd21:   v = 34'sh000001FF;
            5'd22:   v = 34'sh000000FF;
            5'd23:   v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/chd_ctrl.sv -----
// chd_ctrl: sequencer for the compass heading block; steps the datapath
// through tracking, two divisions, cordic and output. Uses chd_pkg.
module chd_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_func,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    input  chd_pkg::t_stat i_stat,
    output chd_pkg::t_cmd  o_cmd
);
    import chd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_TRACK, S_CHECK, S_DIVX, S_DIVY, S_ROT, S_CORD, S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept, w_slot_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.step_idx = r_cnt;
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_out_valid    = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_in_func) begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.res_zero = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        n_state = S_TRACK;
                    end
                end
            end
            S_TRACK: begin
                o_cmd.track = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                if (i_stat.zero_range) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DIVY;
                    n_cnt   = '0;
                end
            end
            S_DIVY: begin
                // first cycle stores x and loads the y division
                o_cmd.div_sel_y = 1'b1;
                o_cmd.div_step  = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS + 1)) begin
                    o_cmd.div_step = 1'b0;
                    o_cmd.div_store = 1'b1;
                    n_state = S_ROT;
                    n_cnt   = '0;
                end else if (r_cnt == '0) begin
                    o_cmd.div_step  = 1'b0;
                    o_cmd.div_store = 1'b1;
                    o_cmd.div_init  = 1'b1;
                end
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                n_cnt     = '0;
                n_state   = S_CORD;
            end
            S_CORD: begin
                o_cmd.cord_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORD_ITERS - 1)) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end
            end
            S_EMIT: begin
                // first cycle after the cordic forms the heading
                if (w_slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hdl/chd_dpath.sv -----
// chd_dpath: calibration extremes, shared restoring divider, iterative
// cordic and output register. Uses chd_pkg; driven by chd_ctrl.
module chd_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chd_pkg::t_in_item    i_in_item,
    input  logic                 i_cfg_we,
    input  logic [14:0]          i_cfg_data,
    input  chd_pkg::t_cmd        i_cmd,
    output chd_pkg::t_stat       o_stat,
    output chd_pkg::t_out_item   o_out_item
);
    import chd_pkg::*;

    logic signed [SMP_W-1:0] r_x, r_y;
    logic signed [SMP_W-1:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi;
    logic signed [DEC_W-1:0] r_decl;
    logic [REM_W-1:0]        r_rem;
    logic [RNG_W-1:0]        r_div_rng;
    logic [QUO_W-1:0]        r_quo;
    logic                    r_neg;
    logic signed [NRM_W-1:0] r_nx, r_ny;
    logic signed [CRD_W-1:0] r_cx, r_cy, r_cz;
    logic                    r_zero_vec;
    logic signed [HDG_W-1:0] r_res_h;
    logic                    r_res_cal;
    logic                    r_pend;
    t_out_item               r_out;

    logic [RNG_W-1:0]        w_xr, w_yr, w_rng;
    logic signed [CTR_W-1:0] w_cx, w_cy, w_c;
    logic [RNG_W-1:0]        w_cmag;
    logic signed [REM_W:0]   w_trial;
    logic                    w_bit;
    logic [REM_W-1:0]        w_keep;
    logic signed [NRM_W-1:0] w_n;
    logic signed [CRD_W-1:0] w_nx, w_ny, w_ysh, w_xsh, w_at, w_z;
    logic signed [CRD_W:0]   w_zr;
    logic signed [SUM_W-1:0] w_ang, w_h, w_hw;
    logic signed [HDG_W-1:0] w_hs;

    assign w_xr = RNG_W'(RNG_W'(r_x_hi) - RNG_W'(r_x_lo));
    assign w_yr = RNG_W'(RNG_W'(r_y_hi) - RNG_W'(r_y_lo));
    assign o_stat.zero_range = (w_xr == '0) || (w_yr == '0);

    // centre by doubling: c = 2v - (hi + lo), |c| <= range
    assign w_cx = (CTR_W'(r_x) <<< 1) - (CTR_W'(r_x_hi) + CTR_W'(r_x_lo));
    assign w_cy = (CTR_W'(r_y) <<< 1) - (CTR_W'(r_y_hi) + CTR_W'(r_y_lo));
    assign w_c    = i_cmd.div_sel_y ? w_cy : w_cx;
    assign w_rng  = i_cmd.div_sel_y ? w_yr : w_xr;
    assign w_cmag = w_c[CTR_W-1] ? RNG_W'(-w_c) : RNG_W'(w_c);

    assign w_trial = $signed({1'b0, r_rem}) - $signed({2'b00, r_div_rng});
    assign w_bit   = !w_trial[REM_W];
    assign w_keep  = w_bit ? w_trial[REM_W-1:0] : r_rem;
    assign w_n     = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    assign w_nx  = CRD_W'(r_nx);
    assign w_ny  = CRD_W'(r_ny);
    assign w_ysh = r_cy >>> i_cmd.step_idx;
    assign w_xsh = r_cx >>> i_cmd.step_idx;
    assign w_at  = atan_q30(i_cmd.step_idx);

    // round the q30 angle to the output format, then add declination, wrap and saturate
    assign w_z   = r_zero_vec ? '0 : r_cz;
    assign w_zr  = (CRD_W+1)'(w_z) + (CRD_W+1)'(ANG_HALF);
    assign w_ang = SUM_W'(w_zr >>> ANG_SHIFT);
    assign w_h   = w_ang + SUM_W'(r_decl);
    always_comb begin
        if (w_h < -TWO_PI_ANG)
            w_hw = w_h + TWO_PI_ANG;
        else if (w_h > TWO_PI_ANG)
            w_hw = w_h - TWO_PI_ANG;
        else
            w_hw = w_h;
        if (w_hw > SUM_W'(32767))
            w_hs = 16'sh7FFF;
        else if (w_hw < -SUM_W'(32768))
            w_hs = 16'sh8000;
        else
            w_hs = w_hw[HDG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo <= '0;
            r_x_hi <= '0;
            r_y_lo <= '0;
            r_y_hi <= '0;
            r_decl <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_decl <= i_cfg_data;
            if (i_cmd.clear) begin
                r_x_lo <= '0;
                r_x_hi <= '0;
                r_y_lo <= '0;
                r_y_hi <= '0;
            end else if (i_cmd.track) begin
                if (r_x < r_x_lo)
                    r_x_lo <= r_x;
                else if (r_x > r_x_hi)
                    r_x_hi <= r_x;
                if (r_y < r_y_lo)
                    r_y_lo <= r_y;
                else if (r_y > r_y_hi)
                    r_y_hi <= r_y;
            end
            // heading is formed the cycle after the last cordic step
            r_pend <= i_cmd.cord_step && (i_cmd.step_idx == CNT_W'(CORD_ITERS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= i_in_item.x_raw;
            r_y <= i_in_item.y_raw;
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel_y && !i_cmd.div_init)
                r_ny <= w_n;
            else
                r_nx <= w_n;
        end
        if (i_cmd.div_init) begin
            r_rem     <= REM_W'(w_cmag);
            r_div_rng <= w_rng;
            r_quo     <= '0;
            r_neg     <= w_c[CTR_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= {w_keep[REM_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_bit};
        end
        if (i_cmd.rot) begin
            r_zero_vec <= (r_nx == '0) && (r_ny == '0);
            if (r_nx < 0) begin
                if (r_ny >= 0) begin
                    r_cx <= w_ny;
                    r_cy <= -w_nx;
                    r_cz <= Q30_HALF_PI;
                end else begin
                    r_cx <= -w_ny;
                    r_cy <= w_nx;
                    r_cz <= -Q30_HALF_PI;
                end
            end else begin
                r_cx <= w_nx;
                r_cy <= w_ny;
                r_cz <= '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_cy >= 0) begin
                r_cx <= r_cx + w_ysh;
                r_cy <= r_cy - w_xsh;
                r_cz <= r_cz + w_at;
            end else begin
                r_cx <= r_cx - w_ysh;
                r_cy <= r_cy + w_xsh;
                r_cz <= r_cz - w_at;
            end
        end
        if (i_cmd.res_zero) begin
            r_res_h   <= '0;
            r_res_cal <= 1'b0;
        end else if (r_pend) begin
            r_res_h   <= w_hs;
            r_res_cal <= 1'b1;
        end
        // a heading taken in its first cycle bypasses the result register
        if (i_cmd.emit) begin
            if (r_pend) begin
                r_out.heading    <= w_hs;
                r_out.calibrated <= 1'b1;
            end else begin
                r_out.heading    <= r_res_h;
                r_out.calibrated <= r_res_cal;
            end
        end
    end

    assign o_out_item = r_out;

endmodule

// ----- hdl/compass_heading_autocal.sv -----
// compass_heading_autocal: magnetometer heading with self-learning min/max
// hard-iron calibration. Top level; uses chd_pkg, chd_ctrl and chd_dpath.
//
// Input channel (i_in_valid / o_in_stall) carries one item: func, x_raw,
// y_raw. func = 1 clears the four calibration extremes and returns heading
// 0, calibrated 0. func = 0 updates the extremes; while either axis range
// is zero the result is heading 0, calibrated 0, else it is atan2 of the
// centred, range-normalised sample plus declination, in Q4.12 radians.
// Output channel (o_out_valid / i_out_stall) gives exactly one result item
// per input item, held in an output register until taken; a stalled result
// does not block acceptance of the next item.
// A clear goes straight to output; a zero-range sample passes track and check;
// a full heading passes track, check, two 30-step restoring divisions on one
// divider, rotate, a 16-step cordic and output. One item at a time; the next
// is taken once the block is back in idle. Declination is written on the
// config channel (i_cfg_valid / o_cfg_ready, always ready); the user must
// write it only while the block is idle, which the block does not enforce.
// Synchronous active-low reset clears extremes and declination, empties output.
module compass_heading_autocal (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  chd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output chd_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [14:0]         i_cfg_data
);
    import chd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    chd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_func   (i_in_item.func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    chd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

endmodule

// ----- dv/testbench.sv -----
// testbench: checks compass_heading_autocal against an in-bench heading predictor
// with random gaps and stalls on both channels. Depends on chd_pkg and the block.
module testbench;
    import chd_pkg::*;

    localparam logic FN_SAMPLE = 1'b0;
    localparam logic FN_CLEAR  = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_data = '0;

    compass_heading_autocal u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    longint    cal_xlo, cal_xhi, cal_ylo, cal_yhi, decl;
    t_out_item heading_q[$];
    int        errors = 0;
    bit        quiet_out = 1'b0;
    bit        hold_out = 1'b0;
    bit        gaps_on = 1'b1;

    const longint atan_tab[16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

    function automatic longint cordic_angle(longint ny, longint nx);
        longint cx, cy, cz, t;
        cx = nx; cy = ny; cz = 0;
        if (nx == 0 && ny == 0) return 0;
        if (nx < 0) begin
            if (ny >= 0) begin
                cx = ny; cy = -nx; cz = 1686629713;
            end else begin
                cx = -ny; cy = nx; cz = -1686629713;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (cy >= 0) begin
                t = cx + (cy >>> i); cy = cy - (cx >>> i); cz += atan_tab[i];
            end else begin
                t = cx - (cy >>> i); cy = cy + (cx >>> i); cz -= atan_tab[i];
            end
            cx = t;
        end
        return cz;
    endfunction

    function automatic t_out_item predict_heading(t_in_item it);
        t_out_item r;
        longint x, y, xr, yr, nx, ny, h, tp;
        r = '0;
        if (it.func == FN_CLEAR) begin
            cal_xlo = 0; cal_xhi = 0; cal_ylo = 0; cal_yhi = 0;
            return r;
        end
        x = longint'(it.x_raw);
        y = longint'(it.y_raw);
        if (x < cal_xlo) cal_xlo = x; else if (x > cal_xhi) cal_xhi = x;
        if (y < cal_ylo) cal_ylo = y; else if (y > cal_yhi) cal_yhi = y;
        xr = cal_xhi - cal_xlo;
        yr = cal_yhi - cal_ylo;
        if (xr == 0 || yr == 0) return r;
        // division truncates toward zero like the divider in chd_dpath
        nx = ((2 * x - (cal_xhi + cal_xlo)) * (64'sd1 <<< 29)) / xr;
        ny = ((2 * y - (cal_yhi + cal_ylo)) * (64'sd1 <<< 29)) / yr;
        h = ((cordic_angle(ny, nx) + (64'sd1 <<< 17)) >>> 18) + decl;
        tp = (64'sd6746518852 + (64'sd1 <<< 17)) >>> 18;
        if (h < -tp) h += tp; else if (h > tp) h -= tp;
        if (h > 32767) h = 32767;
        if (h < -32768) h = -32768;
        r.heading = 16'(h);
        r.calibrated = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (heading_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                t_out_item e;
                e = heading_q.pop_front();
                if (o_out_item.heading !== e.heading)
                    report_mismatch($sformatf("heading %0d expected %0d",
                        o_out_item.heading, e.heading));
                if (o_out_item.calibrated !== e.calibrated)
                    report_mismatch($sformatf("calibrated %0b expected %0b",
                        o_out_item.calibrated, e.calibrated));
            end
        end
        if (hold_out)
            i_out_stall <= 1'b1;
        else
            i_out_stall <= (gaps_on && !quiet_out) ? ($urandom_range(99) < 20) : 1'b0;
    end

    // valid stays high between back-to-back items; this task drops it only in a gap
    task automatic send_item(t_in_item it, bit check_lit, t_out_item lit);
        t_out_item e;
        while (gaps_on && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        e = predict_heading(it);
        if (check_lit && e != lit)
            report_mismatch("predictor disagrees with table entry");
        heading_q.push_back(check_lit ? lit : e);
    endtask

    task automatic write_decl(logic [14:0] v);
        i_in_valid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        decl = longint'($signed(v));
    endtask

    function automatic t_in_item mk(logic f, int x, int y);
        t_in_item it;
        it.func = f; it.x_raw = 16'(x); it.y_raw = 16'(y);
        return it;
    endfunction

    typedef struct {
        t_in_item  it;
        bit        lit;
        t_out_item res;
    } t_row;

    t_row rows[$];

    initial begin
        t_in_item it;
        int decl_set[6] = '{0, 12868, -12868, 16383, -16384, 1};
        cal_xlo = 0; cal_xhi = 0; cal_ylo = 0; cal_yhi = 0; decl = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero range right after reset, clear, extremes, centre, quadrants
        rows.push_back('{mk(FN_SAMPLE, 0, 0), 1, '0});
        rows.push_back('{mk(FN_SAMPLE, 100, 0), 1, '0});
        rows.push_back('{mk(FN_CLEAR, -1, -1), 1, '0});
        rows.push_back('{mk(FN_SAMPLE, 32767, 32767), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, -32768, -32768), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, 32767, -32768), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, -32768, 32767), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, -1, -1), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, 0, 0), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, -32768, 0), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, 0, -32768), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, 32767, 0), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, 0, 32767), 0, '0});
        rows.push_back('{mk(FN_CLEAR, 0, 0), 1, '0});
        rows.push_back('{mk(FN_SAMPLE, 1, -1), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, -1, 1), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, 1, 1), 0, '0});
        rows.push_back('{mk(FN_SAMPLE, -1, -1), 0, '0});
        foreach (rows[i]) send_item(rows[i].it, rows[i].lit, rows[i].res);

        for (int ph = 0; ph < 6; ph++) begin
            write_decl(15'(decl_set[ph]));
            if (ph == 2) begin
                // long receiver hold-off while items keep coming
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            gaps_on = (ph != 3);
            for (int n = 0; n < 222; n++) begin
                int cx, cy, sp;
                if ($urandom_range(99) < 3) begin
                    it = mk(FN_CLEAR, $urandom, $urandom);
                end else begin
                    // mostly samples around a per-phase offset, sometimes wild
                    sp = (n % 3 == 0) ? 32767 : $urandom_range(4000, 10);
                    cx = $signed(16'($urandom_range(2000) * (ph + 1)));
                    cy = -cx / 2;
                    if ($urandom_range(9) == 0)
                        it = mk(FN_SAMPLE, $urandom, $urandom);
                    else
                        it = mk(FN_SAMPLE,
                            cx + $signed($urandom_range(2 * sp)) - sp,
                            cy + $signed($urandom_range(2 * sp)) - sp);
                end
                send_item(it, 0, '0);
            end
            gaps_on = 1'b1;
        end
        i_in_valid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
